// ===== src/rrt_pkg.sv =====
// Shared constants and types for the RIP route table update block.
`timescale 1ns / 1ps
package rrt_pkg;

    // Default configuration
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_NUM_IFACES  = 4;

    // Field widths fixed by the request and result formats
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 6;
    localparam int METRIC_W = 5;
    localparam int ADV_W    = 8;
    localparam int IFACE_W  = 2;
    localparam int REQ_W    = 2;
    localparam int ACT_W    = 3;
    localparam int IN_DATA_W = 112;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DIRECT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    // Result actions
    localparam logic [ACT_W-1:0] ACT_SKIP    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REFRESH = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NOGAIN  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_UNREACH = 3'd5;
    localparam logic [ACT_W-1:0] ACT_FULL    = 3'd6;
    localparam logic [ACT_W-1:0] ACT_READ    = 3'd7;

    // Metrics
    localparam logic [8:0]          INFINITY_METRIC = 9'd16;
    localparam logic [METRIC_W-1:0] DIRECT_METRIC   = 5'd1;
    localparam logic [LEN_W-1:0]    MAX_LEN         = 6'd32;

    // Route attributes as held in the attribute store
    typedef struct packed {
        logic [METRIC_W-1:0] metric;
        logic [IFACE_W-1:0]  iface;
        logic [LEN_W-1:0]    len;
    } t_attr;

endpackage

// ===== src/rip_route_table_update_core.sv =====
// RIP route table: sequenced search, update, insert, delete and read of route entries.
`timescale 1ns / 1ps
// An update or install scans the valid entries, one entry compared per cycle off the single
// table read port, then decides; a delete also moves the last entry into the freed slot.
// A read fetches the indexed entry. A new request is taken only once the last result is
// in the result register, which waits while the result side holds off the last word.
// Reset (i_rst_n low, synchronous) empties the table (count 0) and drops any result held;
// table contents are not cleared, only entries below the count are ever read.
module rip_route_table_update_core #(
    parameter int TABLE_DEPTH = rrt_pkg::DEF_TABLE_DEPTH,
    parameter int NUM_IFACES  = rrt_pkg::DEF_NUM_IFACES,
    parameter int AW          = $clog2(TABLE_DEPTH),
    parameter int CW          = $clog2(TABLE_DEPTH + 1),
    parameter int OUT_W       = ((AW + CW + 78 + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request side
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // prefix_addr[31:0], route_mask[63:32], direct_len[69:64], adv_metric[77:70],
    // sender_addr[109:78], in_iface[111:110]
    input  logic [rrt_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [rrt_pkg::REQ_W-1:0]     s_axis_tuser,
    // result side
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // entry_index, entry_count, out_prefix, out_len, out_metric, out_nexthop,
    // out_iface, skip_split_horizon, zero fill (lowest bit first)
    output logic [OUT_W-1:0]             m_axis_tdata,
    // action[2:0]
    output logic [rrt_pkg::ACT_W-1:0]     m_axis_tuser
);
    import rrt_pkg::*;

    localparam int DATA_W = AW + CW + ADDR_W + LEN_W + METRIC_W + ADDR_W + IFACE_W + 1;
    localparam logic IFACE_ALL = (NUM_IFACES >= 4);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_DEL_WR = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    // Route table: one write port, one registered read port
    logic [ADDR_W-1:0] mem_pfx  [TABLE_DEPTH];
    logic [ADDR_W-1:0] mem_nh   [TABLE_DEPTH];
    t_attr             mem_attr [TABLE_DEPTH];

    // Control state
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;
    logic          r_rd_vld, n_rd_vld;

    // Request word held for the whole operation
    logic [REQ_W-1:0]   r_req, n_req;
    logic [ADDR_W-1:0]  r_pfx, n_pfx;
    logic [ADDR_W-1:0]  r_mask, n_mask;
    logic [LEN_W-1:0]   r_dlen, n_dlen;
    logic [ADV_W-1:0]   r_adv, n_adv;
    logic [ADDR_W-1:0]  r_snd, n_snd;
    logic [IFACE_W-1:0] r_ifc, n_ifc;

    // Search state
    logic [LEN_W-1:0]  r_len, n_len;
    logic [CW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_hit, n_hit;
    logic [AW-1:0]     r_hit_idx, n_hit_idx;
    t_attr             r_hit_attr, n_hit_attr;
    logic [ADDR_W-1:0] r_hit_nh, n_hit_nh;

    // Table read data
    logic [ADDR_W-1:0] r_rd_pfx, r_rd_nh;
    t_attr             r_rd_attr;

    // Pending result
    logic [ACT_W-1:0]    r_res_act, n_res_act;
    logic [AW-1:0]       r_res_idx, n_res_idx;
    logic [ADDR_W-1:0]   r_res_pfx, n_res_pfx;
    logic [LEN_W-1:0]    r_res_len, n_res_len;
    logic [METRIC_W-1:0] r_res_met, n_res_met;
    logic [ADDR_W-1:0]   r_res_nh, n_res_nh;
    logic [IFACE_W-1:0]  r_res_if, n_res_if;
    logic                r_res_sk, n_res_sk;

    // Output word register
    logic [ACT_W-1:0]  r_out_act, n_out_act;
    logic [DATA_W-1:0] r_out_data, n_out_data;

    // Table port controls
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [ADDR_W-1:0] wr_pfx, wr_nh;
    t_attr             wr_attr;

    // Mask to prefix length: isolate the lowest set bit, encode its position
    logic [ADDR_W-1:0] mask_lsb;
    logic [4:0]        mask_pos;
    logic [LEN_W-1:0]  mask_len;
    logic [LEN_W-1:0]  dlen_sat;
    logic              iface_ok;
    logic              match;
    logic [8:0]        metric;
    logic              full;
    logic              read_ok;

    always_comb begin
        mask_lsb = r_mask & (~r_mask + 32'd1);
        mask_pos = '0;
        for (int k = 0; k < ADDR_W; k++) begin
            if (mask_lsb[k]) begin
                mask_pos = mask_pos | 5'(k);
            end
        end
        mask_len = (r_mask == '0) ? '0 : (MAX_LEN - {1'b0, mask_pos});
    end

    assign dlen_sat = (r_dlen > MAX_LEN) ? MAX_LEN : r_dlen;
    assign iface_ok = IFACE_ALL || ({3'b000, r_ifc} < 5'(NUM_IFACES));
    assign match    = r_rd_vld && (r_rd_pfx == r_pfx) && (r_rd_attr.len == r_len);
    assign metric   = {1'b0, r_adv} + 9'd1;
    assign full     = (r_count >= DEPTH_C);
    assign read_ok  = (r_pfx < 32'(r_count));

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_act;
    assign m_axis_tdata  = OUT_W'(r_out_data);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_rd_vld    = r_rd_vld;
        n_req       = r_req;
        n_pfx       = r_pfx;
        n_mask      = r_mask;
        n_dlen      = r_dlen;
        n_adv       = r_adv;
        n_snd       = r_snd;
        n_ifc       = r_ifc;
        n_len       = r_len;
        n_addr      = r_addr;
        n_rd_idx    = r_rd_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_attr  = r_hit_attr;
        n_hit_nh    = r_hit_nh;
        n_res_act   = r_res_act;
        n_res_idx   = r_res_idx;
        n_res_pfx   = r_res_pfx;
        n_res_len   = r_res_len;
        n_res_met   = r_res_met;
        n_res_nh    = r_res_nh;
        n_res_if    = r_res_if;
        n_res_sk    = r_res_sk;
        n_out_act   = r_out_act;
        n_out_data  = r_out_data;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_pfx      = r_pfx;
        wr_nh       = r_snd;
        wr_attr     = '{metric: metric[METRIC_W-1:0], iface: r_ifc, len: r_len};

        // Drop the held result once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_req   = s_axis_tuser;
                    n_pfx   = s_axis_tdata[31:0];
                    n_mask  = s_axis_tdata[63:32];
                    n_dlen  = s_axis_tdata[69:64];
                    n_adv   = s_axis_tdata[77:70];
                    n_snd   = s_axis_tdata[109:78];
                    n_ifc   = s_axis_tdata[111:110];
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_res_act = ACT_NOGAIN;
                n_res_idx = '0;
                n_res_pfx = '0;
                n_res_len = '0;
                n_res_met = '0;
                n_res_nh  = '0;
                n_res_if  = '0;
                n_res_sk  = 1'b0;
                n_hit     = 1'b0;
                n_rd_vld  = 1'b0;
                n_addr    = '0;
                n_state   = S_DONE;
                case (r_req)
                    REQ_READ: begin
                        if (read_ok) begin
                            rd_en     = 1'b1;
                            rd_addr   = r_pfx[AW-1:0];
                            n_res_idx = r_pfx[AW-1:0];
                            n_state   = S_READ;
                        end else begin
                            n_res_act = ACT_UNREACH;
                        end
                    end
                    REQ_UPDATE, REQ_DIRECT: begin
                        if (iface_ok) begin
                            n_len   = (r_req == REQ_UPDATE) ? mask_len : dlen_sat;
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_res_act = ACT_NOGAIN;
                    end
                endcase
            end
            S_SCAN: begin
                // Compare the entry read last cycle while fetching the next one
                n_rd_vld = 1'b0;
                if (match) begin
                    n_hit      = 1'b1;
                    n_hit_idx  = r_rd_idx;
                    n_hit_attr = r_rd_attr;
                    n_hit_nh   = r_rd_nh;
                    n_state    = S_DECIDE;
                end else if (r_addr < r_count) begin
                    rd_en    = 1'b1;
                    rd_addr  = r_addr[AW-1:0];
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_addr[AW-1:0];
                    n_addr   = r_addr + 1'b1;
                end else begin
                    n_hit   = 1'b0;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (r_req == REQ_UPDATE) begin
                    if (r_hit) begin
                        n_res_idx = r_hit_idx;
                        if (r_hit_nh == '0) begin
                            n_res_act = ACT_SKIP;
                        end else if (r_hit_attr.iface == r_ifc) begin
                            if (metric > INFINITY_METRIC) begin
                                // Fetch the last entry to move into the freed slot
                                rd_en     = 1'b1;
                                rd_addr   = AW'(r_count - 1'b1);
                                n_res_act = ACT_DELETE;
                                n_state   = S_DEL_WR;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = r_hit_idx;
                                n_res_act = ACT_REFRESH;
                            end
                        end else if (metric < {4'b0000, r_hit_attr.metric}) begin
                            wr_en     = 1'b1;
                            wr_addr   = r_hit_idx;
                            n_res_act = ACT_REFRESH;
                        end else begin
                            n_res_act = ACT_NOGAIN;
                        end
                    end else if (metric > INFINITY_METRIC) begin
                        n_res_act = ACT_UNREACH;
                    end else if (full) begin
                        n_res_act = ACT_FULL;
                    end else begin
                        wr_en     = 1'b1;
                        wr_addr   = r_count[AW-1:0];
                        n_res_idx = r_count[AW-1:0];
                        n_count   = r_count + 1'b1;
                        n_res_act = ACT_INSERT;
                    end
                end else begin
                    // Direct route install
                    wr_nh   = '0;
                    wr_attr = '{metric: DIRECT_METRIC, iface: r_ifc, len: r_len};
                    if (r_hit) begin
                        wr_en     = 1'b1;
                        wr_addr   = r_hit_idx;
                        n_res_idx = r_hit_idx;
                        n_res_act = ACT_REFRESH;
                    end else if (full) begin
                        n_res_act = ACT_FULL;
                    end else begin
                        wr_en     = 1'b1;
                        wr_addr   = r_count[AW-1:0];
                        n_res_idx = r_count[AW-1:0];
                        n_count   = r_count + 1'b1;
                        n_res_act = ACT_INSERT;
                    end
                end
            end
            S_DEL_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_hit_idx;
                wr_pfx  = r_rd_pfx;
                wr_nh   = r_rd_nh;
                wr_attr = r_rd_attr;
                n_count = r_count - 1'b1;
                n_state = S_DONE;
            end
            S_READ: begin
                n_res_act = ACT_READ;
                n_res_pfx = r_rd_pfx;
                n_res_len = r_rd_attr.len;
                n_res_met = r_rd_attr.metric;
                n_res_nh  = r_rd_nh;
                n_res_if  = r_rd_attr.iface;
                n_res_sk  = (r_rd_attr.iface == r_ifc);
                n_state   = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_act   = r_res_act;
                    n_out_data  = {r_res_sk, r_res_if, r_res_nh, r_res_met, r_res_len,
                                   r_res_pfx, r_count, r_res_idx};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_pfx      <= n_pfx;
        r_mask     <= n_mask;
        r_dlen     <= n_dlen;
        r_adv      <= n_adv;
        r_snd      <= n_snd;
        r_ifc      <= n_ifc;
        r_len      <= n_len;
        r_addr     <= n_addr;
        r_rd_idx   <= n_rd_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_attr <= n_hit_attr;
        r_hit_nh   <= n_hit_nh;
        r_res_act  <= n_res_act;
        r_res_idx  <= n_res_idx;
        r_res_pfx  <= n_res_pfx;
        r_res_len  <= n_res_len;
        r_res_met  <= n_res_met;
        r_res_nh   <= n_res_nh;
        r_res_if   <= n_res_if;
        r_res_sk   <= n_res_sk;
        r_out_act  <= n_out_act;
        r_out_data <= n_out_data;
    end

    // Route table write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_pfx[wr_addr]  <= wr_pfx;
            mem_nh[wr_addr]   <= wr_nh;
            mem_attr[wr_addr] <= wr_attr;
        end
        if (rd_en) begin
            r_rd_pfx  <= mem_pfx[rd_addr];
            r_rd_nh   <= mem_nh[rd_addr];
            r_rd_attr <= mem_attr[rd_addr];
        end
    end

    // The entry count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("route count above table depth");

    // Scan reads only valid entries
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && rd_en) |-> (r_addr < r_count))
        else $error("scan read beyond valid entries");

    // Count moves only on insert or delete
    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DECIDE && r_state != S_DEL_WR) |=> $stable(r_count))
        else $error("route count changed outside insert or delete");

    // Non-read results carry zero entry data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_act != ACT_READ) |->
            (r_out_data[DATA_W-1:AW+CW] == '0))
        else $error("entry data on a non-read result");

    // A delete always removes one entry
    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL_WR) |=> (r_count == $past(r_count) - 1'b1))
        else $error("delete did not shrink the table");

endmodule

// ===== verif/tb_rip_route_table_update_core.sv =====
// Self-checking testbench for the RIP route table update core: directed table plus random traffic.
`timescale 1ns / 1ps
module tb_rip_route_table_update_core;
    import rrt_pkg::*;

    localparam int                CYCLE_LIMIT     = 3000000;
    localparam int                NUM_PHASES      = 8;
    localparam int                ITEMS_PER_PHASE = 232;
    localparam int                POOL_SIZE       = 96;
    localparam int                SETTLE_CYCLES   = 80;
    localparam int                NUM_DIR_ROWS    = 24;
    localparam logic [REQ_W-1:0]  REQ_UNUSED      = 2'd3;
    localparam int                OUT_W           = 96;

    typedef struct packed {
        logic [ACT_W-1:0]    act;
        logic [5:0]          idx;
        logic [6:0]          cnt;
        logic [ADDR_W-1:0]   pfx;
        logic [LEN_W-1:0]    len;
        logic [METRIC_W-1:0] metric;
        logic [ADDR_W-1:0]   nexthop;
        logic [IFACE_W-1:0]  ifc;
        logic                skip;
    } route_result_t;

    // One directed request; typed rows carry action, index and count read off by hand
    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [IFACE_W-1:0] ifc;
        logic [ADDR_W-1:0]  pfx;
        logic [ADDR_W-1:0]  mask;
        logic [LEN_W-1:0]   dlen;
        logic [ADV_W-1:0]   adv;
        logic [ADDR_W-1:0]  snd;
        logic               typed;
        logic [ACT_W-1:0]   act;
        logic [5:0]         idx;
        logic [6:0]         cnt;
    } dir_row_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [REQ_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic [ACT_W-1:0]      m_axis_tuser;

    rip_route_table_update_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Shadow routing table
    logic [ADDR_W-1:0]   tbl_prefix  [DEF_TABLE_DEPTH];
    logic [ADDR_W-1:0]   tbl_nexthop [DEF_TABLE_DEPTH];
    logic [LEN_W-1:0]    tbl_len     [DEF_TABLE_DEPTH];
    logic [IFACE_W-1:0]  tbl_iface   [DEF_TABLE_DEPTH];
    logic [METRIC_W-1:0] tbl_metric  [DEF_TABLE_DEPTH];
    int                  route_count = 0;

    route_result_t pending_route_results [$];
    int            errors      = 0;
    int            cycle_count = 0;
    int            ready_hold  = 0;
    bit            calm        = 1'b0;
    bit            grow        = 1'b1;

    // Route pool so that updates keep hitting existing entries
    logic [ADDR_W-1:0]  pool_pfx   [POOL_SIZE];
    logic [LEN_W-1:0]   pool_len   [POOL_SIZE];
    logic [IFACE_W-1:0] pool_iface [POOL_SIZE];

    dir_row_t directed_rows [NUM_DIR_ROWS] = '{
        // empty table: read, unreachable advert, unused request
        '{REQ_READ,   2'd0, 32'h0,        32'h0,        6'd0,  8'd0,   32'h0,
          1'b1, ACT_UNREACH, 6'd0, 7'd0},
        '{REQ_UPDATE, 2'd0, 32'h0A000000, 32'hFFFFFF00, 6'd0,  8'd255, 32'hC0A80001,
          1'b1, ACT_UNREACH, 6'd0, 7'd0},
        '{REQ_UNUSED, 2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 6'd63, 8'd255, 32'hFFFFFFFF,
          1'b1, ACT_NOGAIN,  6'd0, 7'd0},
        // insert, refresh on same interface, worse and better metric elsewhere
        '{REQ_UPDATE, 2'd1, 32'h0A000000, 32'hFFFFFF00, 6'd0,  8'd0,   32'hC0A80001,
          1'b1, ACT_INSERT,  6'd0, 7'd1},
        '{REQ_UPDATE, 2'd1, 32'h0A000000, 32'hFFFFFF00, 6'd0,  8'd3,   32'hC0A80002,
          1'b1, ACT_REFRESH, 6'd0, 7'd1},
        '{REQ_UPDATE, 2'd2, 32'h0A000000, 32'hFFFFFF00, 6'd0,  8'd7,   32'hC0A80003,
          1'b1, ACT_NOGAIN,  6'd0, 7'd1},
        '{REQ_UPDATE, 2'd2, 32'h0A000000, 32'hFFFFFF00, 6'd0,  8'd1,   32'hC0A80003,
          1'b1, ACT_REFRESH, 6'd0, 7'd1},
        '{REQ_READ,   2'd2, 32'h0,        32'h0,        6'd0,  8'd0,   32'h0,
          1'b0, ACT_READ,    6'd0, 7'd0},
        '{REQ_READ,   2'd3, 32'h0,        32'h0,        6'd0,  8'd0,   32'h0,
          1'b0, ACT_READ,    6'd0, 7'd0},
        // direct installs: saturated length, zero length, skipped updates and an overwrite
        '{REQ_DIRECT, 2'd3, 32'hC0A80000, 32'h0,        6'd63, 8'd0,   32'h0,
          1'b1, ACT_INSERT,  6'd1, 7'd2},
        '{REQ_DIRECT, 2'd0, 32'hFFFFFFFF, 32'h0,        6'd0,  8'd0,   32'h0,
          1'b1, ACT_INSERT,  6'd2, 7'd3},
        '{REQ_UPDATE, 2'd0, 32'hC0A80000, 32'hFFFFFFFF, 6'd0,  8'd0,   32'h0A000009,
          1'b1, ACT_SKIP,    6'd1, 7'd3},
        '{REQ_DIRECT, 2'd0, 32'h0A000000, 32'h0,        6'd24, 8'd0,   32'h0,
          1'b1, ACT_REFRESH, 6'd0, 7'd3},
        '{REQ_UPDATE, 2'd1, 32'hFFFFFFFF, 32'h0,        6'd0,  8'd15,  32'h0A000009,
          1'b1, ACT_SKIP,    6'd2, 7'd3},
        // metric 16 accepted, 17 deletes the last entry, then unreachable
        '{REQ_UPDATE, 2'd3, 32'h12345678, 32'h80000000, 6'd0,  8'd15,  32'hFFFFFFFF,
          1'b1, ACT_INSERT,  6'd3, 7'd4},
        '{REQ_UPDATE, 2'd3, 32'h12345678, 32'h80000000, 6'd0,  8'd16,  32'hFFFFFFFF,
          1'b1, ACT_DELETE,  6'd3, 7'd3},
        '{REQ_UPDATE, 2'd3, 32'h12345678, 32'h80000000, 6'd0,  8'd16,  32'hFFFFFFFF,
          1'b1, ACT_UNREACH, 6'd0, 7'd3},
        // delete from the middle moves the last entry down
        '{REQ_UPDATE, 2'd0, 32'h00000000, 32'hFFFF0000, 6'd0,  8'd0,   32'h00000001,
          1'b1, ACT_INSERT,  6'd3, 7'd4},
        '{REQ_UPDATE, 2'd2, 32'hAC100000, 32'hFFF00000, 6'd0,  8'd2,   32'h0A000002,
          1'b1, ACT_INSERT,  6'd4, 7'd5},
        '{REQ_UPDATE, 2'd0, 32'h00000000, 32'hFFFF0000, 6'd0,  8'd200, 32'h00000001,
          1'b1, ACT_DELETE,  6'd3, 7'd4},
        '{REQ_READ,   2'd2, 32'd3,        32'h0,        6'd0,  8'd0,   32'h0,
          1'b0, ACT_READ,    6'd0, 7'd0},
        // reads beyond the count, then one within it
        '{REQ_READ,   2'd0, 32'hFFFFFFFF, 32'h0,        6'd0,  8'd0,   32'h0,
          1'b1, ACT_UNREACH, 6'd0, 7'd4},
        '{REQ_READ,   2'd0, 32'd4,        32'h0,        6'd0,  8'd0,   32'h0,
          1'b1, ACT_UNREACH, 6'd0, 7'd4},
        '{REQ_READ,   2'd1, 32'd1,        32'h0,        6'd0,  8'd0,   32'h0,
          1'b0, ACT_READ,    6'd0, 7'd0}
    };

    function automatic logic [LEN_W-1:0] netmask_len(input logic [ADDR_W-1:0] mask);
        int n = 32;
        while (n > 0 && mask[0] == 1'b0) begin
            n--;
            mask = mask >> 1;
        end
        return LEN_W'(n);
    endfunction

    function automatic int find_route(input logic [ADDR_W-1:0] pfx,
                                      input logic [LEN_W-1:0] len);
        for (int i = 0; i < route_count; i++)
            if (tbl_prefix[i] == pfx && tbl_len[i] == len) return i;
        return -1;
    endfunction

    function automatic void store_route(input int i, input logic [ADDR_W-1:0] pfx,
                                        input logic [LEN_W-1:0] len,
                                        input logic [IFACE_W-1:0] ifc,
                                        input logic [METRIC_W-1:0] metric,
                                        input logic [ADDR_W-1:0] nexthop);
        tbl_prefix[i]  = pfx;
        tbl_len[i]     = len;
        tbl_iface[i]   = ifc;
        tbl_metric[i]  = metric;
        tbl_nexthop[i] = nexthop;
    endfunction

    // Advance the shadow table by one request and return the result it must produce
    function automatic route_result_t apply_route_request(
        input logic [REQ_W-1:0]   req,
        input logic [ADDR_W-1:0]  pfx,
        input logic [ADDR_W-1:0]  mask,
        input logic [LEN_W-1:0]   dlen,
        input logic [ADV_W-1:0]   adv,
        input logic [ADDR_W-1:0]  snd,
        input logic [IFACE_W-1:0] ifc);
        route_result_t r;
        int            metric;
        int            hit;
        int            last;
        logic [LEN_W-1:0] len;
        r     = '0;
        r.act = ACT_NOGAIN;
        if (req == REQ_UPDATE && int'(ifc) < DEF_NUM_IFACES) begin
            metric = int'(adv) + 1;
            len    = netmask_len(mask);
            hit    = find_route(pfx, len);
            if (hit >= 0) begin
                r.idx = 6'(hit);
                if (tbl_nexthop[hit] == '0) begin
                    r.act = ACT_SKIP;
                end else if (tbl_iface[hit] == ifc) begin
                    if (metric > int'(INFINITY_METRIC)) begin
                        // swap the last entry into the hole and shrink
                        last = route_count - 1;
                        store_route(hit, tbl_prefix[last], tbl_len[last], tbl_iface[last],
                                    tbl_metric[last], tbl_nexthop[last]);
                        route_count = last;
                        r.act = ACT_DELETE;
                    end else begin
                        store_route(hit, pfx, len, ifc, METRIC_W'(metric), snd);
                        r.act = ACT_REFRESH;
                    end
                end else if (metric < int'(tbl_metric[hit])) begin
                    store_route(hit, pfx, len, ifc, METRIC_W'(metric), snd);
                    r.act = ACT_REFRESH;
                end
            end else if (metric > int'(INFINITY_METRIC)) begin
                r.act = ACT_UNREACH;
            end else if (route_count >= DEF_TABLE_DEPTH) begin
                r.act = ACT_FULL;
            end else begin
                store_route(route_count, pfx, len, ifc, METRIC_W'(metric), snd);
                r.idx = 6'(route_count);
                route_count++;
                r.act = ACT_INSERT;
            end
        end else if (req == REQ_DIRECT && int'(ifc) < DEF_NUM_IFACES) begin
            len = (dlen > MAX_LEN) ? MAX_LEN : dlen;
            hit = find_route(pfx, len);
            if (hit >= 0) begin
                store_route(hit, pfx, len, ifc, DIRECT_METRIC, '0);
                r.idx = 6'(hit);
                r.act = ACT_REFRESH;
            end else if (route_count >= DEF_TABLE_DEPTH) begin
                r.act = ACT_FULL;
            end else begin
                store_route(route_count, pfx, len, ifc, DIRECT_METRIC, '0);
                r.idx = 6'(route_count);
                route_count++;
                r.act = ACT_INSERT;
            end
        end else if (req == REQ_READ) begin
            if (pfx < 32'(route_count)) begin
                r.act     = ACT_READ;
                r.idx     = pfx[5:0];
                r.pfx     = tbl_prefix[pfx[5:0]];
                r.len     = tbl_len[pfx[5:0]];
                r.metric  = tbl_metric[pfx[5:0]];
                r.nexthop = tbl_nexthop[pfx[5:0]];
                r.ifc     = tbl_iface[pfx[5:0]];
                r.skip    = (tbl_iface[pfx[5:0]] == ifc);
            end else begin
                r.act = ACT_UNREACH;
            end
        end
        r.cnt = 7'(route_count);
        return r;
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    task automatic issue_request(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] pfx,
                                 input logic [ADDR_W-1:0] mask, input logic [LEN_W-1:0] dlen,
                                 input logic [ADV_W-1:0] adv, input logic [ADDR_W-1:0] snd,
                                 input logic [IFACE_W-1:0] ifc, input bit typed,
                                 input route_result_t typed_res);
        route_result_t want;
        int            gap;
        want = apply_route_request(req, pfx, mask, dlen, adv, snd, ifc);
        if (typed) want = typed_res;
        s_axis_tdata  <= {ifc, snd, adv, dlen, mask, pfx};
        s_axis_tuser  <= req;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_route_results.push_back(want);
        gap = idle_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic issue_random_request();
        logic [REQ_W-1:0]   req;
        logic [ADDR_W-1:0]  pfx;
        logic [ADDR_W-1:0]  mask;
        logic [LEN_W-1:0]   dlen;
        logic [ADV_W-1:0]   adv;
        logic [ADDR_W-1:0]  snd;
        logic [IFACE_W-1:0] ifc;
        int                 kind;
        int                 p;
        int                 r;
        kind = $urandom_range(0, 99);
        p    = $urandom_range(0, POOL_SIZE - 1);
        pfx  = $urandom;
        mask = $urandom;
        dlen = LEN_W'($urandom_range(0, 63));
        adv  = ADV_W'($urandom_range(0, 255));
        snd  = ($urandom_range(0, 99) < 3) ? '0 : ADDR_W'($urandom);
        ifc  = IFACE_W'($urandom_range(0, 3));
        if (kind < 60) begin
            req = REQ_UPDATE;
            if ($urandom_range(0, 99) < 85) begin
                pfx  = pool_pfx[p];
                mask = (pool_len[p] == 0) ? '0 : (32'hFFFFFFFF << (32 - pool_len[p]));
                if ($urandom_range(0, 99) < 70) ifc = pool_iface[p];
            end else if ($urandom_range(0, 1) == 1) begin
                mask = mask << $urandom_range(0, 32);
            end
            r = $urandom_range(0, 99);
            if (grow) begin
                if (r < 85)      adv = ADV_W'($urandom_range(0, 15));
                else if (r < 95) adv = ADV_W'($urandom_range(16, 40));
            end else if (r < 50) begin
                adv = ADV_W'($urandom_range(16, 255));
            end else begin
                adv = ADV_W'($urandom_range(0, 15));
            end
        end else if (kind < 70) begin
            req = REQ_DIRECT;
            pfx = pool_pfx[p];
            if ($urandom_range(0, 99) < 90) dlen = pool_len[p];
        end else if (kind < 95) begin
            req = REQ_READ;
            if ($urandom_range(0, 99) < 80) pfx = $urandom_range(0, route_count + 1);
        end else begin
            req = REQ_UNUSED;
        end
        issue_request(req, pfx, mask, dlen, adv, snd, ifc, 1'b0, '0);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_route_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Check each accepted result word, then pick the next ready stall
    always @(posedge i_clk) begin : result_check
        route_result_t want;
        route_result_t seen;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.act     = m_axis_tuser;
            seen.idx     = m_axis_tdata[5:0];
            seen.cnt     = m_axis_tdata[12:6];
            seen.pfx     = m_axis_tdata[44:13];
            seen.len     = m_axis_tdata[50:45];
            seen.metric  = m_axis_tdata[55:51];
            seen.nexthop = m_axis_tdata[87:56];
            seen.ifc     = m_axis_tdata[89:88];
            seen.skip    = m_axis_tdata[90];
            if (pending_route_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual action %0d",
                         $time, seen.act);
                errors++;
            end else begin
                want = pending_route_results.pop_front();
                check_field("action",      32'(want.act),     32'(seen.act));
                check_field("entry_index", 32'(want.idx),     32'(seen.idx));
                check_field("entry_count", 32'(want.cnt),     32'(seen.cnt));
                check_field("out_prefix",  want.pfx,          seen.pfx);
                check_field("out_len",     32'(want.len),     32'(seen.len));
                check_field("out_metric",  32'(want.metric),  32'(seen.metric));
                check_field("out_nexthop", want.nexthop,      seen.nexthop);
                check_field("out_iface",   32'(want.ifc),     32'(seen.ifc));
                check_field("skip_split",  32'(want.skip),    32'(seen.skip));
            end
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (ready_hold > 0) begin
            m_axis_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_axis_tready <= 1'b1;
            ready_hold = idle_cycles();
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        route_result_t typed_res;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_pfx[i]   = $urandom;
            pool_len[i]   = (i == 0) ? 6'd0 : (i == 1) ? 6'd32 : LEN_W'($urandom_range(0, 32));
            pool_iface[i] = IFACE_W'($urandom_range(0, 3));
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            typed_res     = '0;
            typed_res.act = directed_rows[i].act;
            typed_res.idx = directed_rows[i].idx;
            typed_res.cnt = directed_rows[i].cnt;
            issue_request(directed_rows[i].req, directed_rows[i].pfx, directed_rows[i].mask,
                          directed_rows[i].dlen, directed_rows[i].adv, directed_rows[i].snd,
                          directed_rows[i].ifc, directed_rows[i].typed, typed_res);
        end
        drain_results();

        // Filling phases, every third one a thinning phase; hold off at each boundary until drained
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            grow = (ph % 3 != 2);
            calm = (ph == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) issue_random_request();
            drain_results();
        end
        calm = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_route_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
